>>> rtl/core/ght_pkg.sv
// Package of the generational handle table: command and status codes,
// the beat types of both channels and the table entry layout.
// Depends on nothing; ght_stats and the top level use it.
package ght_pkg;

  localparam int GEN_W = 16;
  localparam int IDX_FIELD_W = 16;

  localparam logic [2:0] CMD_CREATE     = 3'd0;
  localparam logic [2:0] CMD_RELEASE    = 3'd1;
  localparam logic [2:0] CMD_READ       = 3'd2;
  localparam logic [2:0] CMD_BUMP       = 3'd3;
  localparam logic [2:0] CMD_INVALIDATE = 3'd4;
  localparam logic [2:0] CMD_CLEAR      = 3'd5;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic [2:0]         command;
    logic [31:0]        handle;
    logic signed [31:0] init_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        new_handle;
    logic signed [31:0] slot_value_out;
    logic [4:0]         live_count;
    logic [31:0]        created_total;
    logic [31:0]        released_total;
    logic [31:0]        stale_total;
  } out_beat_t;

  // One table entry's bookkeeping word.
  typedef struct packed {
    logic             used;
    logic [GEN_W-1:0] gen;
  } meta_t;

  // Events that the controller hands to the statistics block.
  typedef struct packed {
    logic create;
    logic release_cmd;
    logic stale;
    logic live_dec;
    logic live_zero;
    logic counters_zero;
  } stat_evt_t;

  typedef struct packed {
    logic [31:0] created;
    logic [31:0] released;
    logic [31:0] stale;
  } counts_t;

endpackage

>>> rtl/core/ght_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered
// read. Depends on nothing.
module ght_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the address being written returns the old word.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

>>> rtl/core/ght_stats.sv
// Live entry count and the create, release and stale counters of the
// handle table. Depends on ght_pkg.
module ght_stats #(
  parameter int SLOTS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ght_pkg::stat_evt_t           evt,
  output logic [$clog2(SLOTS+1)-1:0]   live_nxt,
  output ght_pkg::counts_t             counts_nxt
);

  localparam int LW = $clog2(SLOTS + 1);

  logic [LW-1:0]    live_r;
  ght_pkg::counts_t counts_r;

  always_comb begin
    live_nxt   = live_r;
    counts_nxt = counts_r;
    if (evt.live_zero) begin
      live_nxt = '0;
    end else if (evt.create) begin
      live_nxt = live_r + LW'(1);
    end else if (evt.live_dec) begin
      live_nxt = live_r - LW'(1);
    end
    if (evt.counters_zero) begin
      counts_nxt = '0;
    end else begin
      if (evt.create) begin
        counts_nxt.created = counts_r.created + 32'd1;
      end
      if (evt.release_cmd) begin
        counts_nxt.released = counts_r.released + 32'd1;
      end
      if (evt.stale) begin
        counts_nxt.stale = counts_r.stale + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r   <= '0;
      counts_r <= '0;
    end else begin
      live_r   <= live_nxt;
      counts_r <= counts_nxt;
    end
  end

  // The live count can never exceed the number of entries.
  assert property (@(posedge clk) disable iff (!rst_n) live_r <= LW'(SLOTS))
    else $error("live count above table size");

  // A clear leaves all counters at zero in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
      evt.counters_zero |=> (counts_r == '0 && live_r == '0))
    else $error("counters not zeroed by clear");

endmodule

>>> rtl/core/generational_handle_table_top.sv
// Top level of the generational handle table: command sequencer, the
// entry bookkeeping RAM, the value RAM and the statistics block.
// Depends on ght_pkg, ght_ram and ght_stats.
//
// Usage: one command beat enters on in_valid/in_ready and every command
// gives exactly one result beat on out_valid/out_ready. Commands are
// handled one at a time. A beat is looked up in the entry RAMs in the
// cycle after acceptance and its result is registered at the end of that
// cycle once the output register is free. A successful create then scans
// the bookkeeping RAM for the next free entry, one entry per cycle, from
// the entry after the new one up to the next free one, or to the last
// entry when none is free; there is no scan when the new entry is the
// last one. Invalidate-all and clear walk the whole bookkeeping RAM after
// their result is issued. The single RAM read port is why scans and walks
// go one entry at a time. After reset the block clears the bookkeeping
// RAM in a walk with in_ready low. If the receiver stalls, one finished
// result waits in the output register and the block may accept one
// further beat, which then holds in its lookup cycle until the output
// drains. A read and a write of the RAMs may share a cycle, but no read
// whose word is used falls on an entry written in that same cycle.
module generational_handle_table_top #(
  parameter int SLOTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ght_pkg::in_beat_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ght_pkg::out_beat_t out_data
);

  localparam int IW = $clog2(SLOTS);
  localparam int PW = IW + 1;
  localparam int LW = $clog2(SLOTS + 1);
  localparam int MW = $bits(ght_pkg::meta_t);

  // Sequencer states.
  localparam logic [1:0] S_WALK = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_LOOK = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  // What a walk over the bookkeeping RAM does to each entry.
  localparam logic [1:0] WALK_INIT = 2'd0;
  localparam logic [1:0] WALK_INV  = 2'd1;
  localparam logic [1:0] WALK_CLR  = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        walk_mode_r, walk_mode_nxt;
  logic [PW-1:0]     scan_ptr_r, scan_ptr_nxt;
  logic [IW-1:0]     chk_ptr_r, chk_ptr_nxt;
  logic              chk_valid_r, chk_valid_nxt;
  logic [PW-1:0]     free_ptr_r, free_ptr_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic [2:0]        cmd_r, cmd_nxt;
  logic [15:0]       hgen_r, hgen_nxt;
  logic              hbad_r, hbad_nxt;
  logic signed [31:0] init_r, init_nxt;
  logic              out_valid_r, out_valid_nxt;
  ght_pkg::out_beat_t out_data_r, out_data_nxt;

  logic [31:0]       in_packed;
  logic [IW-1:0]     rd_addr;
  logic              meta_we;
  logic [IW-1:0]     meta_wa;
  ght_pkg::meta_t    meta_wd;
  logic [MW-1:0]     meta_rd_raw;
  ght_pkg::meta_t    meta_rd;
  logic              data_we;
  logic [31:0]       data_wd;
  logic [31:0]       data_rd;
  logic              look_hit;
  logic              out_free;
  logic              chk_last;
  logic [PW-1:0]     idx_plus1;
  logic [31:0]       value_res;
  ght_pkg::stat_evt_t evt;
  logic [LW-1:0]     live_nxt;
  ght_pkg::counts_t  counts_nxt;
  logic [1:0]        res_status;
  logic [31:0]       res_handle;
  logic [31:0]       res_value;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_packed = in_data.handle - 32'd1;
  assign meta_rd   = ght_pkg::meta_t'(meta_rd_raw);
  assign out_free  = !out_valid_r || out_ready;
  assign chk_last  = (chk_ptr_r == IW'(SLOTS - 1));
  assign idx_plus1 = PW'(idx_r) + PW'(1);
  assign value_res = data_rd + ((cmd_r == ght_pkg::CMD_BUMP) ? 32'd1 : 32'd0);

  // A handle resolves when it was in range at decode time, its entry is
  // in use and the generations agree.
  assign look_hit = !hbad_r && meta_rd.used && (meta_rd.gen == hgen_r);

  // The RAMs are read at the address of the stage that owns them.
  always_comb begin
    case (state_r)
      S_IDLE: begin
        if (in_data.command == ght_pkg::CMD_CREATE) begin
          rd_addr = free_ptr_r[IW-1:0];
        end else begin
          rd_addr = in_packed[IW-1:0];
        end
      end
      S_LOOK:  rd_addr = idx_r;
      default: rd_addr = scan_ptr_r[IW-1:0];
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    walk_mode_nxt = walk_mode_r;
    scan_ptr_nxt  = scan_ptr_r;
    chk_ptr_nxt   = chk_ptr_r;
    chk_valid_nxt = chk_valid_r;
    free_ptr_nxt  = free_ptr_r;
    idx_nxt       = idx_r;
    cmd_nxt       = cmd_r;
    hgen_nxt      = hgen_r;
    hbad_nxt      = hbad_r;
    init_nxt      = init_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_data_nxt  = out_data_r;
    meta_we       = 1'b0;
    meta_wa       = idx_r;
    meta_wd       = '0;
    data_we       = 1'b0;
    data_wd       = init_r;
    evt           = '0;
    res_status    = ght_pkg::ST_OK;
    res_handle    = '0;
    res_value     = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.command;
          hgen_nxt  = in_packed[31:16];
          hbad_nxt  = (in_data.handle == 32'd0) ||
                      (in_packed[ght_pkg::IDX_FIELD_W-1:0] >= 16'(SLOTS));
          init_nxt  = in_data.init_value;
          idx_nxt   = rd_addr;
          state_nxt = S_LOOK;
        end
      end

      S_LOOK: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          case (cmd_r)
            ght_pkg::CMD_CREATE: begin
              if (free_ptr_r == PW'(SLOTS)) begin
                res_status = ght_pkg::ST_FULL;
              end else begin
                meta_we    = 1'b1;
                meta_wd    = '{used: 1'b1, gen: meta_rd.gen};
                data_we    = 1'b1;
                data_wd    = init_r;
                evt.create = 1'b1;
                res_handle = {meta_rd.gen, 16'(idx_r)} + 32'd1;
                if (idx_plus1 == PW'(SLOTS)) begin
                  free_ptr_nxt = PW'(SLOTS);
                end else begin
                  scan_ptr_nxt  = idx_plus1;
                  chk_valid_nxt = 1'b0;
                  state_nxt     = S_SCAN;
                end
              end
            end
            ght_pkg::CMD_RELEASE: begin
              evt.release_cmd = 1'b1;
              if (look_hit) begin
                meta_we      = 1'b1;
                meta_wd      = '{used: 1'b0, gen: meta_rd.gen};
                evt.live_dec = 1'b1;
                if (PW'(idx_r) < free_ptr_r) begin
                  free_ptr_nxt = PW'(idx_r);
                end
              end else begin
                res_status = ght_pkg::ST_BAD;
              end
            end
            ght_pkg::CMD_READ, ght_pkg::CMD_BUMP: begin
              if (look_hit) begin
                res_value = value_res;
                if (cmd_r == ght_pkg::CMD_BUMP) begin
                  data_we = 1'b1;
                  data_wd = value_res;
                end
              end else begin
                evt.stale  = 1'b1;
                res_status = ght_pkg::ST_BAD;
              end
            end
            ght_pkg::CMD_INVALIDATE, ght_pkg::CMD_CLEAR: begin
              evt.live_zero     = 1'b1;
              evt.counters_zero = (cmd_r == ght_pkg::CMD_CLEAR);
              walk_mode_nxt     = (cmd_r == ght_pkg::CMD_CLEAR) ? WALK_CLR : WALK_INV;
              scan_ptr_nxt      = '0;
              chk_valid_nxt     = 1'b0;
              free_ptr_nxt      = '0;
              state_nxt         = S_WALK;
            end
            default: begin
            end
          endcase
          out_valid_nxt = 1'b1;
          out_data_nxt  = '{status:         res_status,
                            new_handle:     res_handle,
                            slot_value_out: res_value,
                            live_count:     5'(live_nxt),
                            created_total:  counts_nxt.created,
                            released_total: counts_nxt.released,
                            stale_total:    counts_nxt.stale};
        end
      end

      S_SCAN: begin
        // Read one entry ahead and test the one read in the cycle before.
        scan_ptr_nxt  = scan_ptr_r + PW'(1);
        chk_ptr_nxt   = scan_ptr_r[IW-1:0];
        chk_valid_nxt = 1'b1;
        if (chk_valid_r && !meta_rd.used) begin
          free_ptr_nxt = PW'(chk_ptr_r);
          state_nxt    = S_IDLE;
        end else if (chk_valid_r && chk_last) begin
          free_ptr_nxt = PW'(SLOTS);
          state_nxt    = S_IDLE;
        end
      end

      default: begin
        // Walk: read ahead, rewrite the entry read in the cycle before.
        scan_ptr_nxt  = scan_ptr_r + PW'(1);
        chk_ptr_nxt   = scan_ptr_r[IW-1:0];
        chk_valid_nxt = 1'b1;
        meta_wa       = chk_ptr_r;
        if (chk_valid_r) begin
          case (walk_mode_r)
            WALK_INV: begin
              meta_we = meta_rd.used;
              meta_wd = '{used: 1'b0, gen: meta_rd.gen + 16'd1};
            end
            WALK_CLR: begin
              meta_we = 1'b1;
              meta_wd = '{used: 1'b0, gen: meta_rd.gen};
            end
            default: begin
              meta_we = 1'b1;
              meta_wd = '0;
            end
          endcase
          if (chk_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_WALK;
      walk_mode_r <= WALK_INIT;
      scan_ptr_r  <= '0;
      chk_valid_r <= 1'b0;
      free_ptr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_mode_r <= walk_mode_nxt;
      scan_ptr_r  <= scan_ptr_nxt;
      chk_valid_r <= chk_valid_nxt;
      free_ptr_r  <= free_ptr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_ptr_r  <= chk_ptr_nxt;
    idx_r      <= idx_nxt;
    cmd_r      <= cmd_nxt;
    hgen_r     <= hgen_nxt;
    hbad_r     <= hbad_nxt;
    init_r     <= init_nxt;
    out_data_r <= out_data_nxt;
  end

  ght_ram #(
    .WIDTH (MW),
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_we),
    .wr_addr (meta_wa),
    .wr_data (meta_wd),
    .rd_addr (rd_addr),
    .rd_data (meta_rd_raw)
  );

  ght_ram #(
    .WIDTH (32),
    .DEPTH (SLOTS),
    .AW    (IW)
  ) u_data_ram (
    .clk     (clk),
    .wr_en   (data_we),
    .wr_addr (idx_r),
    .wr_data (data_wd),
    .rd_addr (rd_addr),
    .rd_data (data_rd)
  );

  ght_stats #(
    .SLOTS (SLOTS)
  ) u_stats (
    .clk        (clk),
    .rst_n      (rst_n),
    .evt        (evt),
    .live_nxt   (live_nxt),
    .counts_nxt (counts_nxt)
  );

  // The clearing walk keeps the input closed right after reset.
  assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input open during clearing walk");

  // Every accepted beat goes straight to its lookup cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
      (in_valid && in_ready) |=> (state_r == S_LOOK))
    else $error("accepted beat skipped lookup");

  // A new result only ever comes out of a lookup cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
      $rose(out_valid) |-> ($past(state_r) == S_LOOK))
    else $error("result raised outside lookup");

  // The free pointer names an entry or the full mark, nothing beyond.
  assert property (@(posedge clk) disable iff (!rst_n) free_ptr_r <= PW'(SLOTS))
    else $error("free pointer out of range");

endmodule
